>>> rtl/core/strle_pkg.sv
// shared types, constants and diamond tables for the sprite tile run-length decoder
`default_nettype none
package strle_pkg;

  // decode phase codes
  localparam logic [1:0] PH_SKIP  = 2'd0;
  localparam logic [1:0] PH_COUNT = 2'd1;
  localparam logic [1:0] PH_RUN   = 2'd2;

  // configuration register indexes
  localparam logic [7:0] REG_ISOMETRIC_MODE = 8'd0;
  localparam logic [7:0] REG_TILE_LEN       = 8'd1;
  localparam logic [7:0] REG_ORIGIN_X       = 8'd2;
  localparam logic [7:0] REG_ORIGIN_Y       = 8'd3;

  localparam logic [3:0]  ISO_ROWS  = 4'd15;
  localparam logic [15:0] ISO_BYTES = 16'd256;

  typedef struct packed {
    logic [1:0]  phase;
    logic [7:0]  skip_hold;
    logic [7:0]  run_left;
    logic [15:0] column;
    logic [15:0] row;
    logic [15:0] bytes_taken;
    logic [3:0]  diamond_row;
    logic [5:0]  diamond_left;
  } dec_state_t;

  typedef struct packed {
    logic        isometric_mode;
    logic [15:0] tile_len;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
  } cfg_t;

  localparam dec_state_t STATE_RESET = '{
    phase:        PH_SKIP,
    skip_hold:    8'd0,
    run_left:     8'd0,
    column:       16'd0,
    row:          16'd0,
    bytes_taken:  16'd0,
    diamond_row:  4'd0,
    diamond_left: 6'd4
  };

  // first column of each diamond row
  function automatic logic [5:0] iso_start(input logic [3:0] r);
    logic [5:0] v;
    case (r)
      4'd0:    v = 6'd14;
      4'd1:    v = 6'd12;
      4'd2:    v = 6'd10;
      4'd3:    v = 6'd8;
      4'd4:    v = 6'd6;
      4'd5:    v = 6'd4;
      4'd6:    v = 6'd2;
      4'd7:    v = 6'd0;
      4'd8:    v = 6'd2;
      4'd9:    v = 6'd4;
      4'd10:   v = 6'd6;
      4'd11:   v = 6'd8;
      4'd12:   v = 6'd10;
      4'd13:   v = 6'd12;
      4'd14:   v = 6'd14;
      default: v = 6'd0;
    endcase
    return v;
  endfunction

  // pixel count of each diamond row
  function automatic logic [5:0] iso_width(input logic [3:0] r);
    logic [5:0] v;
    case (r)
      4'd0:    v = 6'd4;
      4'd1:    v = 6'd8;
      4'd2:    v = 6'd12;
      4'd3:    v = 6'd16;
      4'd4:    v = 6'd20;
      4'd5:    v = 6'd24;
      4'd6:    v = 6'd28;
      4'd7:    v = 6'd32;
      4'd8:    v = 6'd28;
      4'd9:    v = 6'd24;
      4'd10:   v = 6'd20;
      4'd11:   v = 6'd16;
      4'd12:   v = 6'd12;
      4'd13:   v = 6'd8;
      4'd14:   v = 6'd4;
      default: v = 6'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/strle_step.sv
// per-byte decode step: next decode position and pixel write for one data byte
`default_nettype none
module strle_step (
  input  wire strle_pkg::dec_state_t state,
  input  wire strle_pkg::cfg_t       cfg,
  input  wire                        tile_start,
  input  wire [7:0]                  data_byte,
  output strle_pkg::dec_state_t      state_next,
  output logic                       emit,
  output logic [15:0]                pix_x,
  output logic [15:0]                pix_y
);

  strle_pkg::dec_state_t cur;
  logic [5:0]  iso_col;
  logic [5:0]  left_dec;
  logic [3:0]  row_inc;
  logic [15:0] loc_x;
  logic [15:0] loc_y;

  always_comb begin
    cur        = tile_start ? strle_pkg::STATE_RESET : state;
    state_next = cur;
    emit       = 1'b0;
    loc_x      = cur.column;
    loc_y      = cur.row;
    iso_col    = strle_pkg::iso_start(cur.diamond_row) + strle_pkg::iso_width(cur.diamond_row)
                 - cur.diamond_left;
    left_dec   = cur.diamond_left - 6'd1;
    row_inc    = cur.diamond_row + 4'd1;

    if (cur.bytes_taken < cfg.tile_len) begin
      state_next.bytes_taken = cur.bytes_taken + 16'd1;
      if (cfg.isometric_mode) begin
        if (cfg.tile_len == strle_pkg::ISO_BYTES && cur.diamond_row < strle_pkg::ISO_ROWS
            && cur.diamond_left != 6'd0) begin
          emit  = 1'b1;
          loc_x = {10'd0, iso_col};
          loc_y = {12'd0, cur.diamond_row};
          state_next.diamond_left = left_dec;
          if (left_dec == 6'd0) begin
            state_next.diamond_row  = row_inc;
            state_next.diamond_left = (row_inc < strle_pkg::ISO_ROWS) ?
                                      strle_pkg::iso_width(row_inc) : 6'd0;
          end
        end
      end else begin
        case (cur.phase)
          strle_pkg::PH_COUNT: begin
            if (cur.skip_hold == 8'd0 && data_byte == 8'd0) begin
              state_next.column = 16'd0;
              state_next.row    = cur.row + 16'd1;
              state_next.phase  = strle_pkg::PH_SKIP;
            end else begin
              state_next.column   = cur.column + {8'd0, cur.skip_hold};
              state_next.run_left = data_byte;
              state_next.phase    = (data_byte != 8'd0) ? strle_pkg::PH_RUN : strle_pkg::PH_SKIP;
            end
          end
          strle_pkg::PH_RUN: begin
            emit                = 1'b1;
            state_next.column   = cur.column + 16'd1;
            state_next.run_left = cur.run_left - 8'd1;
            if (cur.run_left == 8'd1) begin
              state_next.phase = strle_pkg::PH_SKIP;
            end
          end
          default: begin
            // skip phase and the unused code
            state_next.skip_hold = data_byte;
            state_next.phase     = strle_pkg::PH_COUNT;
          end
        endcase
      end
    end

    pix_x = cfg.origin_x + loc_x;
    pix_y = cfg.origin_y + loc_y;
  end

endmodule
`default_nettype wire

>>> rtl/core/sprite_tile_rle_decoder_core.sv
// top level of the sprite tile run-length decoder
`default_nettype none
// Sprite sub-tile decoder: takes one encoded byte per transfer and produces
// at most one pixel write (absolute x, y and palette index) per byte. In
// run mode the bytes are (skip, count) pairs followed by count color bytes;
// the pair (0, 0) starts a new row. In isometric mode a 256-byte sub-tile is
// placed on a fixed 15-row diamond; any other length draws nothing. Raise
// tile_start on the first byte of each sub-tile; bytes beyond the tile length
// are dropped silently. Throughput is one byte per clock while the output
// is not stalled: the byte is captured in an input register, the decode step
// is one short combinational stage, and the pixel lands in an output register.
// The running decode position is a single register updated by that stage
// whenever it advances, which is what sets the one-byte-per-cycle figure.
// Write the configuration registers only while the decoder is idle.
module sprite_tile_rle_decoder_core (
  input  wire               clk,
  input  wire               rst,
  // configuration writes
  input  wire               cfg_we,
  input  wire [7:0]         cfg_index,
  input  wire [15:0]        cfg_wdata,
  // byte input
  input  wire               in_valid,
  output logic              in_stall,
  input  wire               tile_start,
  input  wire [7:0]         data_byte,
  // pixel output
  output logic              out_valid,
  input  wire               out_stall,
  output logic signed [15:0] pixel_x,
  output logic signed [15:0] pixel_y,
  output logic [7:0]        pixel_color
);

  strle_pkg::cfg_t       cfg;
  strle_pkg::dec_state_t state;
  strle_pkg::dec_state_t state_next;

  // input register
  logic       s1_valid;
  logic       s1_tile;
  logic [7:0] s1_byte;

  logic        advance;
  logic        emit;
  logic [15:0] pix_x;
  logic [15:0] pix_y;

  // the decode stage moves whenever the output register is free or draining
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        strle_pkg::REG_ISOMETRIC_MODE: cfg.isometric_mode <= cfg_wdata[0];
        strle_pkg::REG_TILE_LEN:       cfg.tile_len       <= cfg_wdata;
        strle_pkg::REG_ORIGIN_X:       cfg.origin_x       <= cfg_wdata;
        strle_pkg::REG_ORIGIN_Y:       cfg.origin_y       <= cfg_wdata;
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_tile <= tile_start;
      s1_byte <= data_byte;
    end
  end

  strle_step u_step (
    .state      (state),
    .cfg        (cfg),
    .tile_start (s1_tile),
    .data_byte  (s1_byte),
    .state_next (state_next),
    .emit       (emit),
    .pix_x      (pix_x),
    .pix_y      (pix_y)
  );

  // decode position, reset counts as the start of a sub-tile
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= strle_pkg::STATE_RESET;
    end else if (s1_valid && advance) begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance && emit) begin
      pixel_x     <= pix_x;
      pixel_y     <= pix_y;
      pixel_color <= s1_byte;
    end
  end

  // a run in progress always has pixels left to draw
  a_run_left: assert property (@(posedge clk) disable iff (rst)
    state.phase == strle_pkg::PH_RUN |-> state.run_left != 8'd0)
    else $error("run phase with empty run count");

  // the diamond only empties once every row is filled
  a_diamond_end: assert property (@(posedge clk) disable iff (rst)
    state.diamond_left == 6'd0 |-> state.diamond_row == strle_pkg::ISO_ROWS)
    else $error("diamond row count out of step with pixels left");

  a_diamond_row: assert property (@(posedge clk) disable iff (rst)
    state.diamond_row <= strle_pkg::ISO_ROWS)
    else $error("diamond row past last row");

  // a held byte that cannot advance keeps the decode position frozen
  a_hold_state: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> $stable(state))
    else $error("decode position moved while stage was blocked");

endmodule
`default_nettype wire

>>> tb/pixel_write_checker.sv
// pixel write checker: predicts pixel writes from observed transfers and compares them
module pixel_write_checker (
  input  wire               clk,
  input  wire               rst,
  input  wire               cfg_we,
  input  wire [7:0]         cfg_index,
  input  wire [15:0]        cfg_wdata,
  input  wire               in_valid,
  input  wire               in_stall,
  input  wire               tile_start,
  input  wire [7:0]         data_byte,
  input  wire               out_valid,
  input  wire               out_stall,
  input  wire signed [15:0] pixel_x,
  input  wire signed [15:0] pixel_y,
  input  wire [7:0]         pixel_color,
  output int                mismatches,
  output int                pixels_pending
);

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  color;
  } pixel_t;

  // shadow configuration
  logic        iso_mode;
  logic [15:0] tile_len;
  logic [15:0] org_x;
  logic [15:0] org_y;

  // shadow decode position
  logic [1:0]  phase;
  logic [7:0]  skip_amt;
  logic [7:0]  run_cnt;
  logic [15:0] col;
  logic [15:0] row_idx;
  logic [15:0] taken;
  logic [3:0]  d_row;
  logic [5:0]  d_left;

  pixel_t expected_pixels[$];

  // distance of a diamond row from the widest (middle) row
  function automatic int row_dist(input logic [3:0] r);
    return (r > 4'd7) ? int'(r) - 7 : 7 - int'(r);
  endfunction

  function automatic logic [5:0] row_span(input logic [3:0] r);
    return 6'(32 - 4 * row_dist(r));
  endfunction

  task automatic clear_position();
    phase    = strle_pkg::PH_SKIP;
    skip_amt = 8'd0;
    run_cnt  = 8'd0;
    col      = 16'd0;
    row_idx  = 16'd0;
    taken    = 16'd0;
    d_row    = 4'd0;
    d_left   = row_span(4'd0);
  endtask

  task automatic push_pixel(input logic [15:0] c, input logic [15:0] r, input logic [7:0] b);
    pixel_t px;
    px.x     = org_x + c;
    px.y     = org_y + r;
    px.color = b;
    expected_pixels.push_back(px);
  endtask

  task automatic decode_byte(input logic ts, input logic [7:0] b);
    logic [15:0] dcol;
    if (ts) clear_position();
    if (taken >= tile_len) return;
    taken = taken + 16'd1;
    if (iso_mode) begin
      if (tile_len != strle_pkg::ISO_BYTES || d_row >= strle_pkg::ISO_ROWS || d_left == 6'd0)
        return;
      dcol = 16'(2 * row_dist(d_row) + int'(row_span(d_row)) - int'(d_left));
      push_pixel(dcol, {12'd0, d_row}, b);
      d_left = d_left - 6'd1;
      if (d_left == 6'd0) begin
        d_row  = d_row + 4'd1;
        d_left = (d_row < strle_pkg::ISO_ROWS) ? row_span(d_row) : 6'd0;
      end
      return;
    end
    case (phase)
      strle_pkg::PH_COUNT: begin
        if (skip_amt == 8'd0 && b == 8'd0) begin
          col     = 16'd0;
          row_idx = row_idx + 16'd1;
          phase   = strle_pkg::PH_SKIP;
        end else begin
          col     = col + {8'd0, skip_amt};
          run_cnt = b;
          phase   = (b != 8'd0) ? strle_pkg::PH_RUN : strle_pkg::PH_SKIP;
        end
      end
      strle_pkg::PH_RUN: begin
        push_pixel(col, row_idx, b);
        col     = col + 16'd1;
        run_cnt = run_cnt - 8'd1;
        if (run_cnt == 8'd0) phase = strle_pkg::PH_SKIP;
      end
      default: begin
        skip_amt = b;
        phase    = strle_pkg::PH_COUNT;
      end
    endcase
  endtask

  always @(posedge clk) begin
    int bad;
    pixel_t want;
    bad = 0;
    if (rst) begin
      iso_mode = 1'b0;
      tile_len = 16'd0;
      org_x    = 16'd0;
      org_y    = 16'd0;
      clear_position();
      expected_pixels.delete();
      mismatches <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          strle_pkg::REG_ISOMETRIC_MODE: iso_mode = cfg_wdata[0];
          strle_pkg::REG_TILE_LEN:       tile_len = cfg_wdata;
          strle_pkg::REG_ORIGIN_X:       org_x    = cfg_wdata;
          strle_pkg::REG_ORIGIN_Y:       org_y    = cfg_wdata;
          default: ;
        endcase
      end
      // compare first so a byte taken on this edge cannot cover for a spurious pixel
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel transfer with none expected: x=%0d y=%0d color=%0d",
                 pixel_x, pixel_y, pixel_color);
          bad = 1;
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_x !== want.x) begin
            $error("pixel_x mismatch: expected %0d, got %0d", $signed(want.x), pixel_x);
            bad += 1;
          end
          if (pixel_y !== want.y) begin
            $error("pixel_y mismatch: expected %0d, got %0d", $signed(want.y), pixel_y);
            bad += 1;
          end
          if (pixel_color !== want.color) begin
            $error("pixel_color mismatch: expected %0d, got %0d", want.color, pixel_color);
            bad += 1;
          end
        end
      end
      if (in_valid && !in_stall) decode_byte(tile_start, data_byte);
      mismatches <= mismatches + bad;
    end
    pixels_pending <= expected_pixels.size();
  end

endmodule

>>> tb/sprite_tile_rle_decoder_core_tb.sv
// testbench top for the sprite tile run-length decoder: stimulus, flow control and verdict
module sprite_tile_rle_decoder_core_tb;

  // generous cycle budget, many times the slowest expected run
  localparam int CYCLE_LIMIT = 600000;
  // target count of byte transfers
  localparam int ITEM_TARGET = 1750;
  // pipeline is two stages deep, let it settle before a register write
  localparam int SETTLE      = 6;

  logic               clk;
  logic               rst         = 1'b1;
  logic               cfg_we      = 1'b0;
  logic [7:0]         cfg_index   = 8'd0;
  logic [15:0]        cfg_wdata   = 16'd0;
  logic               in_valid    = 1'b0;
  logic               tile_start  = 1'b0;
  logic [7:0]         data_byte   = 8'd0;
  logic               out_stall   = 1'b0;
  wire                in_stall;
  wire                out_valid;
  wire signed [15:0]  pixel_x;
  wire signed [15:0]  pixel_y;
  wire [7:0]          pixel_color;

  int mismatches;
  int pixels_pending;

  // flow-control knobs, percent of cycles
  int send_idle_pct = 0;
  int stall_pct     = 0;
  // long receiver hold-off, counted down by the receiver process
  int hold_cycles   = 0;
  int cycle_count   = 0;

  // stimulus bookkeeping
  bit          next_start = 1'b0;
  int          items_sent = 0;
  int          phase_no   = 0;
  int          pick;
  int          len_pick;
  int          target;
  logic [15:0] len;

  sprite_tile_rle_decoder_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .tile_start  (tile_start),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color)
  );

  pixel_write_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .tile_start     (tile_start),
    .data_byte      (data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pixel_x        (pixel_x),
    .pixel_y        (pixel_y),
    .pixel_color    (pixel_color),
    .mismatches     (mismatches),
    .pixels_pending (pixels_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // pixel receiver: random stalls, or a solid hold-off while hold_cycles runs down
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // idling profiles: none, sender idle, receiver stalling, both lightly
  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 87; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 87; end
      default: begin send_idle_pct = 16; stall_pct = 16; end
    endcase
  endtask

  // all four registers on back-to-back cycles, write enable dropped once at the end
  task automatic program_regs(input logic iso, input logic [15:0] length,
                              input logic [15:0] ox, input logic [15:0] oy);
    cfg_we    <= 1'b1;
    cfg_index <= strle_pkg::REG_ISOMETRIC_MODE;
    cfg_wdata <= {15'd0, iso};
    @(posedge clk);
    cfg_index <= strle_pkg::REG_TILE_LEN;
    cfg_wdata <= length;
    @(posedge clk);
    cfg_index <= strle_pkg::REG_ORIGIN_X;
    cfg_wdata <= ox;
    @(posedge clk);
    cfg_index <= strle_pkg::REG_ORIGIN_Y;
    cfg_wdata <= oy;
    @(posedge clk);
    cfg_we  <= 1'b0;
  endtask

  // one byte transfer; tile_start comes from next_start, which is consumed here
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    tile_start <= next_start;
    data_byte  <= b;
    items_sent += 1;
    next_start = 1'b0;
    // stall is stable mid-cycle, so look at it on the falling edge
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  // stop offering, wait for every predicted pixel, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pixels_pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // origins lean toward the wrap points
  function automatic logic [15:0] pick_origin();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // well-formed skip/count stream with random content; noisy tiles mix in
  // stray bytes and early tile restarts
  task automatic send_run_tile(input int budget, input bit noisy);
    int sent;
    int r;
    int cnt;
    logic [7:0] skip;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(99);
      if (noisy && r < 12) begin
        if ($urandom_range(19) == 0) next_start = 1'b1;
        send_byte(8'($urandom));
        sent += 1;
      end else if (r < 22) begin
        // row break
        send_byte(8'h00);
        send_byte(8'h00);
        sent += 2;
      end else if (r < 30) begin
        // skip only, zero count
        send_byte(8'($urandom_range(1, 255)));
        send_byte(8'h00);
        sent += 2;
      end else begin
        skip = (r < 45) ? 8'($urandom) : 8'($urandom_range(0, 5));
        cnt  = (r >= 96) ? $urandom_range(1, 255) : $urandom_range(1, 10);
        send_byte(skip);
        send_byte(8'(cnt));
        repeat (cnt) send_byte(8'($urandom));
        sent += cnt + 2;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----
    set_idling(0);
    // registers still at reset: zero length drops everything
    send_byte(8'hA5);
    send_byte(8'h5A);
    drain();

    // no tile start after reset; origin at the wrap points
    program_regs(1'b0, 16'd12, 16'h7FFF, 16'h8000);
    send_byte(8'd2);      // skip 2
    send_byte(8'd3);      // run of 3
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h5A);
    send_byte(8'h00);     // row break
    send_byte(8'h00);
    send_byte(8'd5);      // skip with zero count
    send_byte(8'h00);
    send_byte(8'd1);      // skip 1, then a run of 255 cut off by the length
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);     // past the length, dropped
    drain();

    // start of the diamond, first row and into the second
    set_idling(1);
    program_regs(1'b1, strle_pkg::ISO_BYTES, 16'h8000, 16'h7FFF);
    next_start = 1'b1;
    repeat (6) send_byte(8'($urandom));
    drain();

    // isometric with the wrong length draws nothing
    set_idling(2);
    program_regs(1'b1, 16'd255, 16'h0000, 16'h0000);
    next_start = 1'b1;
    send_byte(8'h11);
    send_byte(8'h22);
    drain();

    // lone final skip byte, then a dropped byte
    set_idling(3);
    program_regs(1'b0, 16'd1, 16'hFFFF, 16'h0001);
    next_start = 1'b1;
    send_byte(8'h07);
    send_byte(8'h09);
    drain();

    // ---- random part ----
    // each phase: new register set, one or more tiles, full drain before the next write
    while (items_sent < ITEM_TARGET) begin
      set_idling(phase_no % 4);
      // now and then the receiver holds off long enough to back the block up
      if (phase_no % 10 == 3 && hold_cycles == 0) hold_cycles <= 300;
      pick = $urandom_range(99);
      if (pick < 12) begin
        // isometric tiles, mostly partial diamonds restarted by tile_start
        program_regs(1'b1, strle_pkg::ISO_BYTES, pick_origin(), pick_origin());
        repeat ($urandom_range(1, 2)) begin
          next_start = 1'b1;
          target = ($urandom_range(3) == 0) ? 256 : $urandom_range(1, 60);
          repeat (target) send_byte(8'($urandom));
        end
      end else if (pick < 17) begin
        // isometric with a length other than 256
        case ($urandom_range(3))
          0: len = 16'd255;
          1: len = 16'd257;
          2: len = 16'hFFFF;
          default: begin
            len = 16'($urandom_range(1, 300));
            if (len == strle_pkg::ISO_BYTES) len = 16'd257;
          end
        endcase
        program_regs(1'b1, len, pick_origin(), pick_origin());
        next_start = 1'b1;
        repeat ($urandom_range(1, 20)) send_byte(8'($urandom));
      end else begin
        // skip/count tiles; some lengths cut runs short, some run past
        len_pick = $urandom_range(99);
        if (len_pick < 8) len = 16'hFFFF;
        else if (len_pick < 12) len = 16'd0;
        else len = 16'($urandom_range(1, 80));
        program_regs(1'b0, len, pick_origin(), pick_origin());
        repeat ($urandom_range(1, 3)) begin
          next_start = 1'b1;
          if (len == 16'hFFFF) target = $urandom_range(10, 60);
          else if (len == 16'd0) target = 4;
          else target = int'(len) + $urandom_range(0, 3);
          send_run_tile(target, pick > 85);
        end
      end
      drain();
      phase_no += 1;
    end

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
